// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_PLAIN   = 2'd0,
    PH_ESC     = 2'd1,
    PH_HEX     = 2'd2,
    PH_DISCARD = 2'd3
  } jsu_phase_e;

  localparam int unsigned MaxWords = 3;
  localparam int unsigned CntW     = $clog2(MaxWords + 1);

  typedef struct packed {
    jsu_phase_e  phase;
    logic [1:0]  hex_count;
    logic [15:0] code_acc;
    logic        hex_halted;
  } jsu_state_t;

  // The words caused by one input byte. Word 0 is sent first.
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    logic [MaxWords-1:0][7:0]  bytes;
    logic                      byte_valid;
    logic                      escape_error;
    logic                      string_end;
  } jsu_group_t;

endpackage

`default_nettype wire

// ===== sv/jsu_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  jsu_state_t  state_i,
  input  logic [7:0]  in_char_i,
  input  logic        in_last_i,
  output jsu_state_t  state_o,
  output jsu_group_t  group_o
);

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChU      = 8'h75;

  logic        esc_hit;
  logic [7:0]  esc_byte;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic        halted_new;
  logic [15:0] acc_new;

  // Single-byte escapes.
  always_comb begin
    esc_hit  = 1'b1;
    esc_byte = in_char_i;
    unique case (in_char_i)
      ChQuote, ChBslash, ChSlash: esc_byte = in_char_i;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0C;
      8'h6E: esc_byte = 8'h0A;
      8'h72: esc_byte = 8'h0D;
      8'h74: esc_byte = 8'h09;
      default: begin
        esc_hit  = 1'b0;
        esc_byte = 8'h00;
      end
    endcase
  end

  // Hex digit value.
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'h0;
    case (in_char_i) inside
      [8'h30:8'h39]: hex_nib = in_char_i[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: hex_nib = in_char_i[3:0] + 4'd9;
      default: hex_ok = 1'b0;
    endcase
  end

  assign halted_new = state_i.hex_halted | ~hex_ok;
  assign acc_new    = halted_new ? state_i.code_acc : {state_i.code_acc[11:0], hex_nib};

  // Next state.
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PH_PLAIN: begin
        if (in_char_i == ChBslash) begin
          state_o.phase = PH_ESC;
        end
      end
      PH_ESC: begin
        if (esc_hit) begin
          state_o.phase = PH_PLAIN;
        end else if (in_char_i == ChU) begin
          state_o.phase      = PH_HEX;
          state_o.hex_count  = 2'd0;
          state_o.code_acc   = 16'h0000;
          state_o.hex_halted = 1'b0;
        end else begin
          state_o.phase = PH_DISCARD;
        end
      end
      PH_HEX: begin
        if (state_i.hex_count == 2'd3) begin
          state_o.phase      = PH_PLAIN;
          state_o.hex_count  = 2'd0;
          state_o.code_acc   = 16'h0000;
          state_o.hex_halted = 1'b0;
        end else begin
          state_o.hex_count  = state_i.hex_count + 2'd1;
          state_o.code_acc   = acc_new;
          state_o.hex_halted = halted_new;
        end
      end
      PH_DISCARD: state_o.phase = PH_DISCARD;
      default: state_o.phase = PH_PLAIN;
    endcase
    // The final byte of a string always returns the decoder to its idle state.
    if (in_last_i) begin
      state_o.phase      = PH_PLAIN;
      state_o.hex_count  = 2'd0;
      state_o.code_acc   = 16'h0000;
      state_o.hex_halted = 1'b0;
    end
  end

  // Words produced by this byte.
  always_comb begin
    group_o              = '0;
    group_o.string_end   = in_last_i;
    unique case (state_i.phase)
      PH_PLAIN: begin
        if (in_char_i != ChBslash) begin
          group_o.cnt        = CntW'(1);
          group_o.byte_valid = 1'b1;
          group_o.bytes[0]   = in_char_i;
        end else if (in_last_i) begin
          group_o.cnt          = CntW'(1);
          group_o.escape_error = 1'b1;
        end
      end
      PH_ESC: begin
        if (esc_hit) begin
          group_o.cnt        = CntW'(1);
          group_o.byte_valid = 1'b1;
          group_o.bytes[0]   = esc_byte;
        end else if (in_char_i == ChU) begin
          if (in_last_i) begin
            group_o.cnt        = CntW'(1);
            group_o.byte_valid = 1'b1;
          end
        end else begin
          group_o.cnt          = CntW'(1);
          group_o.escape_error = 1'b1;
        end
      end
      PH_HEX: begin
        if (state_i.hex_count == 2'd3 || in_last_i) begin
          group_o.byte_valid = 1'b1;
          if (acc_new[15:7] == 9'd0) begin
            group_o.cnt      = CntW'(1);
            group_o.bytes[0] = {1'b0, acc_new[6:0]};
          end else if (acc_new[15:11] == 5'd0) begin
            group_o.cnt      = CntW'(2);
            group_o.bytes[0] = {3'b110, acc_new[10:6]};
            group_o.bytes[1] = {2'b10, acc_new[5:0]};
          end else begin
            group_o.cnt      = CntW'(3);
            group_o.bytes[0] = {4'b1110, acc_new[15:12]};
            group_o.bytes[1] = {2'b10, acc_new[11:6]};
            group_o.bytes[2] = {2'b10, acc_new[5:0]};
          end
        end
      end
      PH_DISCARD: begin
        if (in_last_i) begin
          group_o.cnt = CntW'(1);
        end
      end
      default: group_o.cnt = CntW'(0);
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake                 | Word contents
// in      | sink      | in_valid_i / in_ready_o   | in_char_i, in_last_i
// out     | source    | out_valid_o / out_ready_i | out_byte_o, byte_valid_o,
//         |           |                           | escape_error_o, run_last_o, string_end_o
//
// One input byte is decoded in the cycle it is accepted and its zero to three
// output words land in a result register, which then drains one word per cycle
// while the output is ready. A byte that makes one word is taken every cycle
// while the output is ready; a unicode escape that makes two or three words
// holds the input until the last of its words leaves the result register.
// Reset (rst_ni low) returns the decoder to plain byte mode with an empty
// result register. A stalled output holds the current word and, once the last
// word of the group is waiting, the input as well.

module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       escape_error_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  jsu_state_t      st_q, st_d;
  jsu_group_t      grp;
  logic [CntW-1:0] cnt_q, cnt_d;
  jsu_group_t      res_q, res_d;
  logic            in_fire, out_fire;

  jsu_decode u_decode (
    .state_i   (st_q),
    .in_char_i (in_char_i),
    .in_last_i (in_last_i),
    .state_o   (st_d),
    .group_o   (grp)
  );

  assign out_valid_o = (cnt_q != CntW'(0));
  assign out_fire    = out_valid_o & out_ready_i;
  // The result register can take a new group when it is empty or its last
  // word leaves in this cycle.
  assign in_ready_o  = (cnt_q == CntW'(0)) | ((cnt_q == CntW'(1)) & out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    res_d = res_q;
    if (in_fire) begin
      cnt_d = grp.cnt;
      res_d = grp;
    end else if (out_fire) begin
      cnt_d          = cnt_q - CntW'(1);
      res_d.bytes[0] = res_q.bytes[1];
      res_d.bytes[1] = res_q.bytes[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // The current word is always at the head of the result register.
  assign out_byte_o     = res_q.bytes[0];
  assign byte_valid_o   = res_q.byte_valid;
  assign escape_error_o = res_q.escape_error;
  assign run_last_o     = (cnt_q == CntW'(1));
  assign string_end_o   = run_last_o & res_q.string_end;

`ifndef SYNTHESIS
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end flagged on a word that is not last of its group");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && escape_error_o |-> run_last_o && !byte_valid_o)
    else $error("error word is not a lone word without data");

  a_multi_is_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > CntW'(1) |-> byte_valid_o && !escape_error_o)
    else $error("multi-word group that is not a UTF-8 sequence");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_i |=> st_q.phase == PH_PLAIN && st_q.code_acc == 16'h0000)
    else $error("decoder state not cleared after the final byte");

  a_hex_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != PH_HEX |-> st_q.hex_count == 2'd0 && !st_q.hex_halted
                             && st_q.code_acc == 16'h0000)
    else $error("escape digit state left over outside a unicode escape");
`endif

endmodule

`default_nettype wire

// ===== verif/json_string_unescape_utf8_unit_tb.sv =====
`timescale 1ns / 1ps

import jsu_pkg::*;

localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_U      = "u";
// The eight characters that may follow a backslash as a two-byte escape.
localparam logic [63:0] ESC_CHARS = "\"\\/bfnrt";

// Scoreboard: tracks the decoder state for each accepted input byte and
// holds the output words that byte is expected to produce.
class unescape_scoreboard;
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       escape_error;
    logic       run_last;
    logic       string_end;
  } word_t;

  jsu_phase_e  phase;
  logic [1:0]  hex_count;
  logic [15:0] code_acc;
  logic        hex_halted;
  word_t       decoded_q[$];
  word_t       group_q[$];
  int          errors;

  function new();
    clear_state();
    errors = 0;
  endfunction

  function void clear_state();
    phase      = PH_PLAIN;
    hex_count  = 2'd0;
    code_acc   = 16'h0000;
    hex_halted = 1'b0;
  endfunction

  // Value of a hex digit, or -1 for any other byte.
  static function int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Byte produced by a two-byte escape, or -1 if c does not form one.
  static function int escape_byte(logic [7:0] c);
    case (c)
      "\"":    return 8'h22;
      "\\":    return 8'h5C;
      "/":     return 8'h2F;
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return -1;
    endcase
  endfunction

  function void add_word(logic [7:0] b, logic bv, logic ee);
    word_t w;
    w = '{out_byte: b, byte_valid: bv, escape_error: ee, run_last: 1'b0, string_end: 1'b0};
    group_q.push_back(w);
  endfunction

  function void add_utf8(logic [15:0] cp);
    if (cp <= 16'h007F) begin
      add_word(cp[7:0], 1'b1, 1'b0);
    end else if (cp <= 16'h07FF) begin
      add_word({3'b110, cp[10:6]}, 1'b1, 1'b0);
      add_word({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      add_word({4'b1110, cp[15:12]}, 1'b1, 1'b0);
      add_word({2'b10, cp[11:6]}, 1'b1, 1'b0);
      add_word({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  // Advance the decoder by one accepted byte and queue the words it causes.
  function void decode_byte(logic [7:0] c, logic last);
    int d;
    int m;
    group_q.delete();
    case (phase)
      PH_PLAIN: begin
        if (c == CH_BSLASH) begin
          if (last) add_word(8'h00, 1'b0, 1'b1);
          else phase = PH_ESC;
        end else begin
          add_word(c, 1'b1, 1'b0);
        end
      end
      PH_ESC: begin
        m = escape_byte(c);
        if (m >= 0) begin
          add_word(m[7:0], 1'b1, 1'b0);
          phase = PH_PLAIN;
        end else if (c == CH_U) begin
          phase      = PH_HEX;
          hex_count  = 2'd0;
          code_acc   = 16'h0000;
          hex_halted = 1'b0;
          if (last) add_utf8(code_acc);
        end else begin
          add_word(8'h00, 1'b0, 1'b1);
          phase = PH_DISCARD;
        end
      end
      PH_HEX: begin
        d = hex_val(c);
        // The first non-hex byte freezes the code point; the remaining
        // positions are still consumed.
        if (!hex_halted && d >= 0) code_acc = {code_acc[11:0], d[3:0]};
        else hex_halted = 1'b1;
        if (hex_count == 2'd3 || last) begin
          add_utf8(code_acc);
          clear_state();
        end else begin
          hex_count = hex_count + 2'd1;
        end
      end
      default: begin
        if (last) add_word(8'h00, 1'b0, 1'b0);
      end
    endcase
    if (group_q.size() > 0) begin
      group_q[group_q.size()-1].run_last   = 1'b1;
      group_q[group_q.size()-1].string_end = last;
    end
    if (last) clear_state();
    foreach (group_q[i]) decoded_q.push_back(group_q[i]);
  endfunction

  function void cmp_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      errors++;
    end
  endfunction

  function void check_word(word_t got);
    word_t e;
    if (decoded_q.size() == 0) begin
      $error("output word with nothing expected: out_byte %0h", got.out_byte);
      errors++;
      return;
    end
    e = decoded_q.pop_front();
    cmp_field("out_byte", e.out_byte, got.out_byte);
    cmp_field("byte_valid", e.byte_valid, got.byte_valid);
    cmp_field("escape_error", e.escape_error, got.escape_error);
    cmp_field("run_last", e.run_last, got.run_last);
    cmp_field("string_end", e.string_end, got.string_end);
  endfunction
endclass

module json_string_unescape_utf8_unit_tb;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_char_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       escape_error_o;
  logic       run_last_o;
  logic       string_end_o;

  unescape_scoreboard sb;

  // Bytes of the string currently being sent.
  logic [7:0] text_q[$];
  int         bytes_sent;
  int         burst_left;
  // Set by the sender to ask the receiver for one long hold-off.
  bit         hold_req;

  json_string_unescape_utf8_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .escape_error_o (escape_error_o),
    .run_last_o     (run_last_o),
    .string_end_o   (string_end_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Generous ceiling on the length of the run.
  initial begin
    #200_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ASCII hex digit for a nibble, in either case.
  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  // Offer one word on the input channel and wait until it is taken. The
  // sender works in bursts; a gap drops valid only between words, so valid
  // is never lowered and raised in the same step.
  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      // Roughly one burst in four follows directly, giving stretches with
      // no idling on the sender side.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.decode_byte(c, last);
    bytes_sent++;
  endtask

  // Send text_q as one string, flagging its final byte.
  task automatic send_text_q();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_string(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text_q();
  endtask

  // Build a random string body in text_q. Nearly half of the tokens are
  // well-formed escapes with random content, so the hex and UTF-8 paths are
  // reached often; the rest are raw bytes, broken \u sequences, unknown escapes
  // and dangling backslashes.
  task automatic make_random_text();
    int          ntok;
    int          kind;
    int          pos;
    int          ndig;
    logic [15:0] cp;
    logic [7:0]  b;
    bit          done;
    text_q.delete();
    ntok = $urandom_range(1, 5);
    done = 1'b0;
    for (int t = 0; t < ntok && !done; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Raw byte; a backslash is mostly steered away so that strings
        // are not dominated by accidental escapes.
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
        text_q.push_back(b);
      end else if (kind < 55) begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(ESC_CHARS[8*$urandom_range(0, 7) +: 8]);
      end else if (kind < 88) begin
        // \u escape; the code point range picks a 1, 2 or 3 byte encoding.
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        // From 80 up one position carries a non-hex byte.
        pos = (kind < 80) ? 4 : $urandom_range(0, 3);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 0; i < 4; i++) begin
          if (i == pos) begin
            do b = 8'($urandom_range(0, 255)); while (sb.hex_val(b) >= 0);
            text_q.push_back(b);
          end else begin
            text_q.push_back(hex_char(cp[15-4*i -: 4], 1'($urandom_range(0, 1))));
          end
        end
      end else if (kind < 94) begin
        // String ends inside \u after zero to three digits.
        ndig = $urandom_range(0, 3);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 0; i < ndig; i++)
          text_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1))));
        done = 1'b1;
      end else if (kind < 98) begin
        // Unknown escape; everything after it is discarded.
        do b = 8'($urandom_range(0, 255));
        while (sb.escape_byte(b) >= 0 || b == CH_U);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(b);
      end else begin
        text_q.push_back(CH_BSLASH);
        done = 1'b1;
      end
    end
  endtask

  // Output monitor: every accepted word is checked against the oldest
  // expectation. Outputs are registered, so sampling at the edge sees the
  // value that was present during the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word('{out_byte: out_byte_o, byte_valid: byte_valid_o,
                      escape_error: escape_error_o, run_last: run_last_o,
                      string_end: string_end_o});
  end

  // Receiver: its stall pattern cycles through always ready, mostly ready,
  // a fixed pattern and a coin toss. Once, on request from the sender, it
  // holds off so that the result register fills and the input channel stalls.
  initial begin
    int  cyc;
    int  hold_left;
    bit  hold_done;
    cyc         = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        hold_left   = 80;
        out_ready_i <= 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= (cyc % 5 != 2);
          default: out_ready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Sender and end of run.
  initial begin
    sb         = new();
    bytes_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_char_i  <= 8'h00;
    in_last_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings. The null code point must come out as a single
    // zero byte, and a surrogate is encoded on its own as three bytes.
    send_string("\\u0000");
    send_string("\\uD83d");
    // Accumulation halts at 'g'; the hex digits after it are consumed but
    // not added, giving 0x7F.
    send_string("\\u7fgA");
    // Unknown escape, then the final byte while discarding.
    send_string("\\qx");
    // Backslash as the final byte.
    send_string("\\");
    // String ends inside \u with one digit gathered.
    send_string("\\u1");
    // Extremes of the raw byte range.
    text_q = '{8'h00, 8'hFF};
    send_text_q();

    while (bytes_sent < 130) begin
      if (bytes_sent >= 60) hold_req = 1'b1;
      make_random_text();
      send_text_q();
    end
    in_valid_i <= 1'b0;

    // Drain, then keep watching for any stray word before the verdict.
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
